FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the Jaccard distance block.
// No dependencies; define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("invariant violated");
// A condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("next-cycle check violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, cond, conseq)
`endif
`endif

FILE: hdl/bvjd_pkg.sv
// Package for the bit vector Jaccard distance block: sizes, item types
// and the structs passed between the lane, merge and divider stages.
`default_nettype none
package bvjd_pkg;

    localparam int LANES      = 64;
    localparam int MAX_BITS   = 65536;
    localparam int FRAC_BITS  = 16;

    localparam int DATA_W     = 64;
    localparam int VC_W       = 7;
    localparam int DIST_W     = FRAC_BITS + 1;
    localparam int TOTAL_W    = 17;

    localparam int GROUP_SIZE = 8;
    localparam int GROUPS     = (LANES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_CNT_W  = $clog2(GROUP_SIZE + 1);
    localparam int LANE_CNT_W = $clog2(LANES + 1);
    localparam int ACC_W      = $clog2(MAX_BITS + 1);
    localparam int DIV_STEPS  = DIST_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [DATA_W-1:0] bits_a;
        logic [DATA_W-1:0] bits_b;
        logic [VC_W-1:0]   valid_count;
        logic              last_chunk;
    } chunk_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic               empty_union;
        logic [TOTAL_W-1:0] differ_total;
        logic [TOTAL_W-1:0] union_total;
        logic               overflow;
    } result_t;

    // Per-group popcounts leaving the lane stage.
    typedef struct packed {
        logic                             vld;
        logic                             last;
        logic [GROUPS-1:0][GRP_CNT_W-1:0] differ_grp;
        logic [GROUPS-1:0][GRP_CNT_W-1:0] union_grp;
    } grp_stage_t;

    // Final row totals handed to the divider.
    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] differ_cnt;
        logic [ACC_W-1:0] union_cnt;
        logic             saturated;
    } row_t;

endpackage
`default_nettype wire

FILE: hdl/bvjd_lanes.sv
// Lane stage: one cell per bit pair forms the differ and union bits, and
// each group of eight lanes is counted into a register. Uses bvjd_pkg.
`default_nettype none
module bvjd_lanes (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire bvjd_pkg::chunk_t    chunk,
    output bvjd_pkg::grp_stage_t     grp
);
    import bvjd_pkg::*;

    logic [VC_W-1:0]                  n_lanes;
    logic [LANES-1:0]                 differ_bit;
    logic [LANES-1:0]                 union_bit;
    logic [GROUPS-1:0][GRP_CNT_W-1:0] differ_grp_next;
    logic [GROUPS-1:0][GRP_CNT_W-1:0] union_grp_next;
    logic [GROUPS-1:0][GRP_CNT_W-1:0] differ_grp_reg;
    logic [GROUPS-1:0][GRP_CNT_W-1:0] union_grp_reg;
    logic                             vld_reg;
    logic                             last_reg;

    // A count above the lane count covers all lanes.
    assign n_lanes = (chunk.valid_count > VC_W'(LANES)) ? VC_W'(LANES) : chunk.valid_count;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (VC_W'(i) < n_lanes)
            begin
                differ_bit[i] = chunk.bits_a[i] ^ chunk.bits_b[i];
                union_bit[i]  = chunk.bits_a[i] | chunk.bits_b[i];
            end
            else
            begin
                differ_bit[i] = 1'b0;
                union_bit[i]  = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            differ_grp_next[g] = '0;
            union_grp_next[g]  = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < LANES)
                begin
                    differ_grp_next[g] = differ_grp_next[g]
                        + GRP_CNT_W'(differ_bit[g * GROUP_SIZE + k]);
                    union_grp_next[g]  = union_grp_next[g]
                        + GRP_CNT_W'(union_bit[g * GROUP_SIZE + k]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            last_reg       <= chunk.last_chunk;
            differ_grp_reg <= differ_grp_next;
            union_grp_reg  <= union_grp_next;
        end
    end

    assign grp.vld        = vld_reg;
    assign grp.last       = last_reg;
    assign grp.differ_grp = differ_grp_reg;
    assign grp.union_grp  = union_grp_reg;

endmodule
`default_nettype wire

FILE: hdl/bvjd_merge.sv
// Merge stage: adds the group counts into chunk counts, then folds them
// into the saturating row accumulators. Uses bvjd_pkg.
`default_nettype none
module bvjd_merge (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bvjd_pkg::grp_stage_t grp,
    output bvjd_pkg::row_t            row
);
    import bvjd_pkg::*;

    logic [LANE_CNT_W-1:0] differ_sum_next;
    logic [LANE_CNT_W-1:0] union_sum_next;
    logic [LANE_CNT_W-1:0] differ_sum_reg;
    logic [LANE_CNT_W-1:0] union_sum_reg;
    logic                  vld_reg;
    logic                  last_reg;
    logic [ACC_W-1:0]      differ_acc_reg;
    logic [ACC_W-1:0]      differ_acc_next;
    logic [ACC_W-1:0]      union_acc_reg;
    logic [ACC_W-1:0]      union_acc_next;
    logic                  saturated_reg;
    logic                  saturated_next;
    logic [ACC_W:0]        differ_raw;
    logic [ACC_W:0]        union_raw;
    logic                  differ_over;
    logic                  union_over;

    always_comb
    begin
        differ_sum_next = '0;
        union_sum_next  = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            differ_sum_next = differ_sum_next + LANE_CNT_W'(grp.differ_grp[g]);
            union_sum_next  = union_sum_next + LANE_CNT_W'(grp.union_grp[g]);
        end
    end

    // Sums above the limit clamp to the limit and set the sticky flag.
    assign differ_raw  = {1'b0, differ_acc_reg} + (ACC_W + 1)'(differ_sum_reg);
    assign union_raw   = {1'b0, union_acc_reg} + (ACC_W + 1)'(union_sum_reg);
    assign differ_over = differ_raw > (ACC_W + 1)'(MAX_BITS);
    assign union_over  = union_raw > (ACC_W + 1)'(MAX_BITS);

    always_comb
    begin
        differ_acc_next = differ_over ? ACC_W'(MAX_BITS) : differ_raw[ACC_W-1:0];
        union_acc_next  = union_over ? ACC_W'(MAX_BITS) : union_raw[ACC_W-1:0];
        saturated_next  = saturated_reg | differ_over | union_over;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= 1'b0;
            differ_acc_reg <= '0;
            union_acc_reg  <= '0;
            saturated_reg  <= 1'b0;
        end
        else
        begin
            vld_reg <= grp.vld;
            if (vld_reg)
            begin
                if (last_reg)
                begin
                    differ_acc_reg <= '0;
                    union_acc_reg  <= '0;
                    saturated_reg  <= 1'b0;
                end
                else
                begin
                    differ_acc_reg <= differ_acc_next;
                    union_acc_reg  <= union_acc_next;
                    saturated_reg  <= saturated_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp.vld)
        begin
            last_reg       <= grp.last;
            differ_sum_reg <= differ_sum_next;
            union_sum_reg  <= union_sum_next;
        end
    end

    assign row.done       = vld_reg & last_reg;
    assign row.differ_cnt = differ_acc_next;
    assign row.union_cnt  = union_acc_next;
    assign row.saturated  = saturated_next;

endmodule
`default_nettype wire

FILE: hdl/bvjd_divider.sv
// Restoring divider: one quotient bit per cycle of differ * 2^16 / union,
// holding the finished row result until it is taken. Uses bvjd_pkg.
`default_nettype none
module bvjd_divider (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bvjd_pkg::row_t row,
    input  wire logic          ack,
    output logic               done,
    output bvjd_pkg::result_t  result
);
    import bvjd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [ACC_W-1:0]    rem_reg;
    logic [ACC_W-1:0]    divisor_reg;
    logic [ACC_W-1:0]    differ_reg;
    logic [DIV_STEPS-1:0] bits_reg;
    logic [DIST_W-1:0]   quo_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                sat_reg;
    logic [ACC_W:0]      trial;
    logic [ACC_W:0]      trial_sub;
    logic                fits;
    logic [ACC_W-1:0]    rem_next;
    logic [31:0]         differ_wide;
    logic [31:0]         union_wide;

    assign trial     = {rem_reg, bits_reg[DIV_STEPS-1]};
    assign trial_sub = trial - {1'b0, divisor_reg};
    assign fits      = trial >= {1'b0, divisor_reg};
    assign rem_next  = fits ? trial_sub[ACC_W-1:0] : trial[ACC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rem_reg     <= '0;
            divisor_reg <= '0;
            differ_reg  <= '0;
            bits_reg    <= '0;
            quo_reg     <= '0;
            step_reg    <= '0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (row.done)
                    begin
                        // The quotient never exceeds 2^16, so the top dividend
                        // bits start out as the remainder.
                        rem_reg     <= row.differ_cnt >> 1;
                        bits_reg    <= {row.differ_cnt[0], {FRAC_BITS{1'b0}}};
                        divisor_reg <= row.union_cnt;
                        differ_reg  <= row.differ_cnt;
                        sat_reg     <= row.saturated;
                        quo_reg     <= '0;
                        step_reg    <= STEP_W'(DIV_STEPS - 1);
                        state_reg   <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    rem_reg  <= rem_next;
                    bits_reg <= bits_reg << 1;
                    quo_reg  <= {quo_reg[DIST_W-2:0], fits};
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (ack)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign differ_wide = 32'(differ_reg);
    assign union_wide  = 32'(divisor_reg);

    always_comb
    begin
        done                = state_reg == ST_DONE;
        result.empty_union  = divisor_reg == '0;
        result.distance     = result.empty_union ? '0 : quo_reg;
        result.differ_total = differ_wide[TOTAL_W-1:0];
        result.union_total  = union_wide[TOTAL_W-1:0];
        result.overflow     = sat_reg;
    end

endmodule
`default_nettype wire

FILE: hdl/bit_vector_jaccard_distance.sv
// Top level of the bit vector Jaccard distance block: handshakes, row
// sequencing and the result register. Uses bvjd_pkg, bvjd_lanes,
// bvjd_merge, bvjd_divider and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Two bit rows stream in as items of up to 64 bit pairs each, one item per
// clock cycle while chunk_stall is low. For every item the lane cells count
// the positions that differ and the positions where either bit is set (only
// the low valid_count pairs count; a count above 64 means all 64), group
// counters and a merge stage add these up, and saturating row accumulators
// collect them, clamping at MAX_BITS and setting the overflow flag. An item
// with last_chunk set closes the row: the totals go to a restoring divider
// that finds differ * 65536 / union, truncated, one quotient bit per cycle,
// and the result item leaves through an output register. A row with an
// empty union reports distance 0 with empty_union set. Chunks that do not
// close a row are taken every cycle. After a closing chunk the input stalls
// through the two count stages, the divider's 17 steps and the load of the
// result register, longer if the result register is still full; the next
// row can start while that result waits to be taken.
module bit_vector_jaccard_distance (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             chunk_valid,
    output logic                  chunk_stall,
    input  wire bvjd_pkg::chunk_t chunk,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output bvjd_pkg::result_t     result
);
    import bvjd_pkg::*;

    logic       take;
    grp_stage_t grp;
    row_t       row;
    logic       div_done;
    result_t    div_result;
    logic       load;
    logic       row_busy_reg;
    logic       row_busy_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    result_t    res_reg;

    // Once a closing chunk is in, nothing more is taken until its result
    // has moved into the output register.
    assign take = chunk_valid & ~row_busy_reg;

    bvjd_lanes u_lanes (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .chunk (chunk),
        .grp   (grp)
    );

    bvjd_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .grp   (grp),
        .row   (row)
    );

    bvjd_divider u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .row    (row),
        .ack    (load),
        .done   (div_done),
        .result (div_result)
    );

    // The divider hands over its result when the output register is empty
    // or is being emptied in this cycle.
    assign load = div_done & (~res_valid_reg | ~result_stall);

    always_comb
    begin
        row_busy_next = row_busy_reg;
        if (take && chunk.last_chunk)
        begin
            row_busy_next = 1'b1;
        end
        else if (load)
        begin
            row_busy_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_busy_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            row_busy_reg  <= row_busy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= div_result;
        end
    end

    assign chunk_stall  = row_busy_reg;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Differ never exceeds union, so the distance stays at or below 1.0.
    `ASSERT_ALWAYS(a_dist_range, clk, rst_n, !result_valid || result.distance <= 17'd65536)
    // An empty union always reports a zero distance.
    `ASSERT_ALWAYS(a_empty_zero, clk, rst_n,
        !(result_valid && result.empty_union) || result.distance == '0)
    // A closing chunk blocks the input on the next cycle.
    `ASSERT_NEXT(a_last_blocks, clk, rst_n, chunk_valid && !chunk_stall && chunk.last_chunk,
        chunk_stall)
    // A new result only appears as the row it closes releases the input.
    `ASSERT_ALWAYS(a_result_ends_row, clk, rst_n, !$rose(result_valid) || $past(chunk_stall))

endmodule
`default_nettype wire
